@@ rtl/core/spv_pkg.sv @@
// ----------------------------------------------------------------------------
// spv_pkg
// Types, character codes and the grammar step function of the SMTP path
// validator.
// ----------------------------------------------------------------------------
package spv_pkg;

   // Character codes
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_DIGIT0 = 8'h30;
   localparam logic [7:0] CH_DIGIT9 = 8'h39;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_RBRACK = 8'h5D;

   // Byte class codes
   localparam logic [1:0] CLS_DROP = 2'd0;
   localparam logic [1:0] CLS_ADDR = 2'd1;
   localparam logic [1:0] CLS_TAIL = 2'd2;

   // Grammar steps needed to settle any byte (longest chain of
   // non-consuming moves plus the consuming one)
   localparam int SPV_STEPS = 5;

   typedef enum logic [15:0] {
      PH_LEAD        = 16'h0001,
      PH_ROUTE       = 16'h0002,
      PH_ROUTE_AT    = 16'h0004,
      PH_DOM         = 16'h0008,
      PH_DOM_NUM     = 16'h0010,
      PH_DOM_LIT     = 16'h0020,
      PH_DOM_ATOM    = 16'h0040,
      PH_DOM_END     = 16'h0080,
      PH_EMPTY       = 16'h0100,
      PH_LOCAL       = 16'h0200,
      PH_LOCAL_QUOTE = 16'h0400,
      PH_LOCAL_ATOM  = 16'h0800,
      PH_LOCAL_END   = 16'h1000,
      PH_CLOSE       = 16'h2000,
      PH_TAIL        = 16'h4000,
      PH_FAIL        = 16'h8000
   } spv_phase_type;

   typedef struct packed {
      spv_phase_type phase;
      logic          bracketed;
      logic          route_open;
      logic          escape_next;
      logic          part_nonempty;
      logic          failed;
   } spv_state_type;

   // Parser state plus what has been decided for the current byte
   typedef struct packed {
      spv_state_type st;
      logic          used;
      logic [1:0]    cls;
      logic          accepted;
   } spv_walk_type;

   typedef struct packed {
      logic [1:0] byte_class;
      logic       path_done;
      logic       path_valid;
   } spv_result_type;

   localparam spv_state_type ST_START = '{PH_LEAD, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

   function automatic logic spv_is_special(logic [7:0] c);
      logic sp;
      case (c) inside
         CH_LPAREN, CH_RPAREN, CH_LT, CH_GT, CH_AT, CH_COMMA, CH_SEMI, CH_COLON,
         CH_BSLASH, CH_DQUOTE, CH_DOT, CH_LBRACK, CH_RBRACK, CH_SPACE: sp = 1'b1;
         default: sp = 1'b0;
      endcase
      return sp;
   endfunction

   function automatic logic spv_is_atom(logic [7:0] c);
      return (c != CH_NUL) && ((c == CH_DOT) || !spv_is_special(c));
   endfunction

   // A failure takes the byte at once as dropped
   function automatic spv_walk_type spv_fail(spv_walk_type w_in);
      spv_walk_type w;
      w          = w_in;
      w.st.failed = 1'b1;
      w.st.phase = PH_FAIL;
      w.used     = 1'b1;
      w.cls      = CLS_DROP;
      return w;
   endfunction

   // One grammar move; does nothing once the byte has been taken
   function automatic spv_walk_type spv_step(spv_walk_type w_in, logic [7:0] c, logic m,
                                             logic pmb);
      spv_walk_type w;
      logic [1:0]   dcls;
      w    = w_in;
      dcls = w.st.route_open ? CLS_DROP : CLS_ADDR;
      if (!w.used) begin
         unique case (w.st.phase)
            PH_LEAD: begin
               if (c == CH_SPACE) begin
                  w.used = 1'b1;
               end else if (c == CH_LT) begin
                  w.st.bracketed = 1'b1;
                  w.st.phase     = PH_ROUTE;
                  w.used         = 1'b1;
               end else if (pmb) begin
                  w.st.bracketed = 1'b0;
                  w.st.phase     = PH_ROUTE;
               end else begin
                  w = spv_fail(w);
               end
            end
            PH_ROUTE: begin
               if (c == CH_AT) begin
                  w.st.route_open = 1'b1;
                  w.st.phase      = PH_DOM;
                  w.used          = 1'b1;
               end else begin
                  w.st.phase = PH_EMPTY;
               end
            end
            PH_ROUTE_AT: begin
               if (c == CH_AT) begin
                  w.st.phase = PH_DOM;
                  w.used     = 1'b1;
               end else begin
                  w = spv_fail(w);
               end
            end
            PH_DOM: begin
               if (c == CH_HASH) begin
                  w.st.phase = PH_DOM_NUM;
                  w.cls      = dcls;
                  w.used     = 1'b1;
               end else if (c == CH_LBRACK) begin
                  w.st.escape_next = 1'b0;
                  w.st.phase       = PH_DOM_LIT;
                  w.cls            = dcls;
                  w.used           = 1'b1;
               end else begin
                  w.st.part_nonempty = 1'b0;
                  w.st.phase         = PH_DOM_ATOM;
               end
            end
            PH_DOM_NUM: begin
               if (c >= CH_DIGIT0 && c <= CH_DIGIT9) begin
                  w.cls  = dcls;
                  w.used = 1'b1;
               end else begin
                  w.st.phase = PH_DOM_END;
               end
            end
            PH_DOM_LIT: begin
               if (c == CH_NUL) begin
                  w = spv_fail(w);
               end else if (w.st.escape_next) begin
                  w.st.escape_next = 1'b0;
                  w.cls            = dcls;
                  w.used           = 1'b1;
               end else if (c == CH_RBRACK) begin
                  w.st.phase = PH_DOM_END;
                  w.cls      = dcls;
                  w.used     = 1'b1;
               end else if (c == CH_DQUOTE || c == CH_LF) begin
                  w = spv_fail(w);
               end else begin
                  if (c == CH_BSLASH) begin
                     w.st.escape_next = 1'b1;
                  end
                  w.cls  = dcls;
                  w.used = 1'b1;
               end
            end
            PH_DOM_ATOM: begin
               if (spv_is_atom(c)) begin
                  w.st.part_nonempty = 1'b1;
                  w.cls              = dcls;
                  w.used             = 1'b1;
               end else if (w.st.part_nonempty) begin
                  w.st.phase = PH_DOM_END;
               end else begin
                  w = spv_fail(w);
               end
            end
            PH_DOM_END: begin
               if (!w.st.route_open) begin
                  w.st.phase = PH_CLOSE;
               end else if (c == CH_COMMA) begin
                  w.st.phase = PH_ROUTE_AT;
                  w.used     = 1'b1;
               end else if (c == CH_COLON) begin
                  w.st.route_open = 1'b0;
                  w.st.phase      = PH_EMPTY;
                  w.used          = 1'b1;
               end else begin
                  w = spv_fail(w);
               end
            end
            PH_EMPTY: begin
               w.st.phase = (c == CH_GT && m) ? PH_CLOSE : PH_LOCAL;
            end
            PH_LOCAL: begin
               if (c == CH_DQUOTE) begin
                  w.st.escape_next = 1'b0;
                  w.st.phase       = PH_LOCAL_QUOTE;
                  w.cls            = CLS_ADDR;
                  w.used           = 1'b1;
               end else begin
                  w.st.part_nonempty = 1'b0;
                  w.st.phase         = PH_LOCAL_ATOM;
               end
            end
            PH_LOCAL_QUOTE: begin
               if (c == CH_NUL) begin
                  w = spv_fail(w);
               end else if (w.st.escape_next) begin
                  w.st.escape_next = 1'b0;
                  w.cls            = CLS_ADDR;
                  w.used           = 1'b1;
               end else begin
                  if (c == CH_DQUOTE) begin
                     w.st.phase = PH_LOCAL_END;
                  end else if (c == CH_BSLASH) begin
                     w.st.escape_next = 1'b1;
                  end
                  w.cls  = CLS_ADDR;
                  w.used = 1'b1;
               end
            end
            PH_LOCAL_ATOM: begin
               if (spv_is_atom(c)) begin
                  w.st.part_nonempty = 1'b1;
                  w.cls              = CLS_ADDR;
                  w.used             = 1'b1;
               end else if (w.st.part_nonempty) begin
                  w.st.phase = PH_LOCAL_END;
               end else begin
                  w = spv_fail(w);
               end
            end
            PH_LOCAL_END: begin
               if (c == CH_AT) begin
                  w.st.route_open = 1'b0;
                  w.st.phase      = PH_DOM;
                  w.cls           = CLS_ADDR;
                  w.used          = 1'b1;
               end else begin
                  w = spv_fail(w);
               end
            end
            PH_CLOSE: begin
               if (w.st.bracketed) begin
                  if (c == CH_GT) begin
                     w.st.phase = PH_TAIL;
                     w.used     = 1'b1;
                  end else begin
                     w = spv_fail(w);
                  end
               end else if (c == CH_GT) begin
                  w = spv_fail(w);
               end else begin
                  w.st.phase = PH_TAIL;
               end
            end
            PH_TAIL: begin
               if (c == CH_NUL) begin
                  w.accepted = 1'b1;
                  w.used     = 1'b1;
               end else if (m) begin
                  w.cls  = CLS_TAIL;
                  w.used = 1'b1;
               end else begin
                  w = spv_fail(w);
               end
            end
            PH_FAIL: begin
               w.cls  = CLS_DROP;
               w.used = 1'b1;
            end
            default: begin
               w = spv_fail(w);
            end
         endcase
      end
      return w;
   endfunction

endpackage

@@ rtl/core/spv_parser.sv @@
// ----------------------------------------------------------------------------
// spv_parser
// Path grammar state and the per-byte decision: settles one byte from the
// current state and advances the state when the byte moves on.
// ----------------------------------------------------------------------------
module spv_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step_en,
   input  logic [7:0]              char_in,
   input  logic                    mode,
   input  logic                    permit_missing_brackets,
   output spv_pkg::spv_result_type result
);

   spv_pkg::spv_state_type path_ff;
   spv_pkg::spv_state_type path_in;
   spv_pkg::spv_walk_type  walk [0:spv_pkg::SPV_STEPS];
   spv_pkg::spv_walk_type  fin;
   logic                   is_end;

   // Chain of grammar moves; non-consuming moves fall through to the next one
   always_comb begin
      walk[0].st       = path_ff;
      walk[0].used     = 1'b0;
      walk[0].cls      = spv_pkg::CLS_DROP;
      walk[0].accepted = 1'b0;
      for (int i = 0; i < spv_pkg::SPV_STEPS; i++) begin
         walk[i+1] = spv_pkg::spv_step(walk[i], char_in, mode, permit_missing_brackets);
      end
   end

   always_comb begin
      fin = walk[spv_pkg::SPV_STEPS];
      if (!fin.used) begin
         fin = spv_pkg::spv_fail(fin);
      end
   end

   assign is_end = (char_in == spv_pkg::CH_NUL);

   assign result.byte_class = fin.cls;
   assign result.path_done  = is_end;
   assign result.path_valid = is_end & fin.accepted & ~fin.st.failed;

   // The zero byte closes the path whatever the phase
   assign path_in = is_end ? spv_pkg::ST_START : fin.st;

   always_ff @(posedge clock) begin
      if (reset) begin
         path_ff <= spv_pkg::ST_START;
      end else if (step_en) begin
         path_ff <= path_in;
      end
   end

endmodule

@@ rtl/core/smtp_path_validator_unit.sv @@
// ----------------------------------------------------------------------------
// smtp_path_validator_unit
// Checks an SMTP reverse or forward path one byte per cycle against the
// RFC821 path grammar and labels each byte as dropped, address or trailing
// parameter text; the zero byte that ends a path carries the verdict. Every
// byte gives exactly one result. Throughput is one byte per clock while
// rsp_stall does not hold the result register: a byte is held in an input
// register, settled by the grammar logic and placed in the result register,
// which drives rsp_valid. The path state update sets this rate. The mode
// register (permit_missing_brackets) is written through the csr_ port, which
// is always ready, and should only be changed while no path is in flight.
// ----------------------------------------------------------------------------
module smtp_path_validator_unit (
   input  logic       clock,
   input  logic       reset,
   // input items
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_in,
   input  logic       req_mode,
   // result items
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_byte_class,
   output logic       rsp_path_done,
   output logic       rsp_path_valid,
   // configuration
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_permit_missing_brackets
);

   logic                    in_vld_ff, in_vld_in;
   logic [7:0]              in_char_ff, in_char_in;
   logic                    in_mode_ff, in_mode_in;
   logic                    out_vld_ff, out_vld_in;
   logic [7:0]              out_byte_ff, out_byte_in;
   spv_pkg::spv_result_type out_res_ff, out_res_in;
   logic                    pmb_ff, pmb_in;
   spv_pkg::spv_result_type res;
   logic                    advance;
   logic                    req_take;

   assign advance   = in_vld_ff & (~out_vld_ff | ~rsp_stall);
   assign req_stall = in_vld_ff & ~advance;
   assign req_take  = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      in_vld_in   = req_take | (in_vld_ff & ~advance);
      in_char_in  = req_take ? req_char_in : in_char_ff;
      in_mode_in  = req_take ? req_mode : in_mode_ff;
      out_vld_in  = advance | (out_vld_ff & rsp_stall);
      out_byte_in = advance ? in_char_ff : out_byte_ff;
      out_res_in  = advance ? res : out_res_ff;
      pmb_in      = (csr_valid & csr_ready) ? csr_permit_missing_brackets : pmb_ff;
   end

   spv_parser u_parser (
      .clock                   (clock),
      .reset                   (reset),
      .step_en                 (advance),
      .char_in                 (in_char_ff),
      .mode                    (in_mode_ff),
      .permit_missing_brackets (pmb_ff),
      .result                  (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         pmb_ff     <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         pmb_ff     <= pmb_in;
      end
   end

   always_ff @(posedge clock) begin
      in_char_ff  <= in_char_in;
      in_mode_ff  <= in_mode_in;
      out_byte_ff <= out_byte_in;
      out_res_ff  <= out_res_in;
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_byte_class = out_res_ff.byte_class;
   assign rsp_path_done  = out_res_ff.path_done;
   assign rsp_path_valid = out_res_ff.path_valid;

   // done flag tracks the zero byte
   a_done_on_nul: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_path_done == (rsp_out_byte == spv_pkg::CH_NUL)))
      else $error("path_done does not match terminating byte");

   a_valid_only_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_path_valid |-> rsp_path_done)
      else $error("path_valid raised on a non-terminating item");

   a_done_dropped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_path_done |-> rsp_byte_class == spv_pkg::CLS_DROP)
      else $error("terminating byte not classed as dropped");

   a_class_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_byte_class != 2'd3)
      else $error("byte_class out of range");

   // tail text only exists in sender mode
   a_tail_sender: assert property (@(posedge clock) disable iff (reset)
      advance && res.byte_class == spv_pkg::CLS_TAIL |-> in_mode_ff)
      else $error("trailing text classed in recipient mode");

endmodule
